@@ hdl/assert_macros.svh @@
// Assertion helpers for the deque checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

@@ hdl/cdq_pkg.sv @@
`timescale 1ns / 1ps

package cdq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_POP_RD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;    // input beat accepted this cycle
		logic finish;  // pop read data is ready to load into the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic res_valid;  // result register holds an undelivered beat
		logic pop_hit;    // pending input is a pop on a non-empty deque
	} dp_stat_t;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 4;

endpackage

@@ hdl/cdq_ctrl.sv @@
`timescale 1ns / 1ps

module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_stall,
	input  cdq_pkg::dp_stat_t stat,
	output logic              in_stall,
	output cdq_pkg::cmd_t     cmd
);

	cdq_pkg::state_t state_q;
	cdq_pkg::state_t state_next;
	logic            can_take;

	// In idle, the result register is free when empty or being drained this cycle.
	assign can_take = (state_q == cdq_pkg::S_IDLE) && (!stat.res_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			cdq_pkg::S_IDLE: begin
				if (can_take && in_valid && stat.pop_hit) begin
					state_next = cdq_pkg::S_POP_RD;
				end
			end
			cdq_pkg::S_POP_RD: begin
				state_next = cdq_pkg::S_IDLE;
			end
			default: begin
				state_next = cdq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = !can_take;
		cmd.take   = can_take && in_valid;
		cmd.finish = (state_q == cdq_pkg::S_POP_RD);
	end

endmodule

@@ hdl/cdq_dp.sv @@
`timescale 1ns / 1ps

module cdq_dp #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdq_pkg::cmd_t                       cmd,
	input  logic                                out_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [cdq_pkg::VALUE_W-1:0]  push_value,
	output cdq_pkg::dp_stat_t                   stat,
	output logic                                out_valid,
	output logic signed [cdq_pkg::VALUE_W-1:0]  pop_value,
	output logic [1:0]                          status,
	output logic [cdq_pkg::COUNT_W-1:0]         entry_count
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic signed [cdq_pkg::VALUE_W-1:0] mem_q [DEPTH];
	logic signed [cdq_pkg::VALUE_W-1:0] rd_data_q;

	logic [IDX_W-1:0] front_q, rear_q, front_next, rear_next;
	logic [CNT_W-1:0] count_q, count_next;
	logic             res_valid_q;
	logic [1:0]       res_status_q;
	logic [cdq_pkg::COUNT_W-1:0] res_count_q;
	logic signed [cdq_pkg::VALUE_W-1:0] res_value_q;

	logic             is_push, is_empty, is_full;
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	cdq_pkg::status_t op_status;
	logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;

	assign is_push  = (opcode == cdq_pkg::OP_PUSH_FRONT) || (opcode == cdq_pkg::OP_PUSH_REAR);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == FULL_CNT);

	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign rear_inc  = (rear_q == LAST_IDX) ? '0 : rear_q + 1'b1;
	assign rear_dec  = (rear_q == '0) ? LAST_IDX : rear_q - 1'b1;

	always_comb begin
		front_next = front_q;
		rear_next  = rear_q;
		count_next = count_q;
		wr_en      = 1'b0;
		wr_addr    = '0;
		rd_en      = 1'b0;
		rd_addr    = front_q;
		op_status  = cdq_pkg::ST_DONE;
		if (is_push) begin
			if (is_full) begin
				op_status = cdq_pkg::ST_OVERFLOW;
			end else begin
				wr_en      = cmd.take;
				count_next = count_q + 1'b1;
				priority if (is_empty) begin
					front_next = '0;
					rear_next  = '0;
					wr_addr    = '0;
				end else if (opcode == cdq_pkg::OP_PUSH_FRONT) begin
					front_next = front_dec;
					wr_addr    = front_dec;
				end else begin
					rear_next = rear_inc;
					wr_addr   = rear_inc;
				end
			end
		end else begin
			if (is_empty) begin
				op_status = cdq_pkg::ST_UNDERFLOW;
			end else begin
				rd_en      = cmd.take;
				count_next = count_q - 1'b1;
				if (opcode == cdq_pkg::OP_POP_FRONT) begin
					rd_addr    = front_q;
					front_next = front_inc;
				end else begin
					rd_addr   = rear_q;
					rear_next = rear_dec;
				end
				if (count_q == CNT_W'(1)) begin
					front_next = '0;
					rear_next  = '0;
				end
			end
		end
	end

	assign stat.pop_hit   = !is_push && !is_empty;
	assign stat.res_valid = res_valid_q;

	// Storage: one write port for pushes, one registered read port for pops.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			rear_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				front_q <= front_next;
				rear_q  <= rear_next;
				count_q <= count_next;
			end
			priority if (cmd.take && !stat.pop_hit) begin
				res_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_status_q <= op_status;
			res_count_q  <= cdq_pkg::COUNT_W'(count_next);
			res_value_q  <= '0;
		end else if (cmd.finish) begin
			res_value_q <= rd_data_q;
		end
	end

	assign out_valid   = res_valid_q;
	assign pop_value   = res_value_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

endmodule

@@ hdl/circular_deque.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Fields
// input     in         in_valid / in_stall   opcode, push_value
// result    out        out_valid / out_stall pop_value, status, entry_count
//
// A push, or a pop on an empty deque, shows its result in the cycle after its beat.
// A successful pop passes through the registered read port of the storage, then the result register.
// A new beat is taken when the result register is empty or drains in that cycle,
// but never in the cycle in which a pop read completes.
// Reset clears the indices, the count and the result flag; storage is not cleared.
// A stalled result holds its fields and blocks only further input beats.

module circular_deque #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [cdq_pkg::VALUE_W-1:0]  push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cdq_pkg::VALUE_W-1:0]  pop_value,
	output logic [1:0]                          status,
	output logic [cdq_pkg::COUNT_W-1:0]         entry_count
);

	// Commands travel from the controller to the datapath, status the other way.
	cdq_pkg::cmd_t     cmd;
	cdq_pkg::dp_stat_t stat;

	// The controller decides when a beat is taken and when a pop read completes.
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	// The datapath holds the ring storage, both end indices, the count and
	// the result register.
	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.out_stall   (out_stall),
		.opcode      (opcode),
		.push_value  (push_value),
		.stat        (stat),
		.out_valid   (out_valid),
		.pop_value   (pop_value),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule

@@ hdl/cdq_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdq_checker #(
	parameter int unsigned DEPTH = 8
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [cdq_pkg::VALUE_W-1:0] pop_value,
	input logic [1:0]                         status,
	input logic [cdq_pkg::COUNT_W-1:0]        entry_count
);

	localparam logic [cdq_pkg::COUNT_W-1:0] FULL_SHOWN = cdq_pkg::COUNT_W'(DEPTH);

	// A result held by the sink stays put.
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pop_value) && $stable(status) && $stable(entry_count))

	// Overflowed pushes and failed pops never carry a value.
	`ASSERT_IMPLY(a_zero_value, clk, arst_n, out_valid && (status != cdq_pkg::ST_DONE), pop_value == '0)

	// Underflow is only possible with the deque empty.
	`ASSERT_IMPLY(a_underflow_empty, clk, arst_n, out_valid && (status == cdq_pkg::ST_UNDERFLOW), entry_count == '0)

	// Overflow is only possible with the deque full.
	`ASSERT_IMPLY(a_overflow_full, clk, arst_n, out_valid && (status == cdq_pkg::ST_OVERFLOW), entry_count == FULL_SHOWN)

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
